### rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants, initial hash values and sigma functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_DIGEST
    } state_t;

    // schedule window control
    typedef struct packed {
        logic push;   // shift a loaded word in at the top
        logic step;   // shift in the next expanded word
    } sched_ctrl_t;

    // round unit control
    typedef struct packed {
        logic load;   // working variables take the chaining words
        logic step;   // one compression round
    } round_ctrl_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t msg_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic word_t msg_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

### rtl/core/sha256_message_hash_top.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher, top level
// Byte-serial SHA-256 with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Message bytes come in one per input item on s_tdata, with s_tuser set when
// the item carries a byte and s_tlast on the final item of a message. One
// item is taken per cycle while idle; the 64th byte of each block starts a
// compression that holds s_tready low while the single round unit runs the
// 64 rounds and a step then folds the result into the chaining words, so no
// byte is taken while a block is being compressed.
// The end of a message is padded one byte a cycle, but for any compression,
// through the same byte path: the pad marker, zero fill up to byte 56 of the
// block (plus a state to spot it), then the eight length bytes and the final
// compression. A marker that lands at byte 56 or later closes its block with
// an extra compression first. The digest is then offered as eight output
// items, most significant word first, one per cycle while m_tready is high.
// No new message is accepted until word 7 is taken.
// ----------------------------------------------------------------------------
module sha256_message_hash_top
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] byte_present
    input  logic        s_tlast,    // end_of_message

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tuser,    // [0] length_overflow
    output logic        m_tlast     // last_word
);

    // sequencer state
    state_t       state_reg, state_next;
    state_t       resume_reg, resume_next;
    logic [5:0]   round_reg, round_next;
    logic [2:0]   idx_reg, idx_next;

    // message bookkeeping
    logic [60:0]  total_reg, total_next;
    logic [60:0]  total_inc;
    logic         ovf_reg, ovf_next;
    logic [5:0]   pos_reg, pos_next;
    logic [23:0]  part_reg, part_next;
    logic [63:0]  len_reg, len_next;

    word_t        chain_reg [8];
    word_t        chain_next [8];
    word_t        vars [8];
    word_t        wt;
    word_t        push_word;

    // byte insertion path, shared by message bytes and padding
    logic         ins_en;
    logic [7:0]   ins_byte;
    logic         block_full;

    sched_ctrl_t  sched_ctrl;
    round_ctrl_t  round_ctrl;

    assign total_inc  = total_reg + 61'd1;
    assign push_word  = {part_reg, ins_byte};
    assign block_full = ins_en && (pos_reg == BLOCK_LAST);

    assign sched_ctrl.push = ins_en && (pos_reg[1:0] == 2'd3);
    assign sched_ctrl.step = (state_reg == ST_COMP);
    assign round_ctrl.load = block_full;
    assign round_ctrl.step = (state_reg == ST_COMP);

    sha256_sched u_sched (
        .aclk      (aclk),
        .ctrl      (sched_ctrl),
        .push_word (push_word),
        .wt        (wt)
    );

    sha256_round u_round (
        .aclk   (aclk),
        .ctrl   (round_ctrl),
        .chain  (chain_reg),
        .wt     (wt),
        .k_word (ROUND_K[round_reg]),
        .vars   (vars)
    );

    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        len_next    = len_reg;
        chain_next  = chain_reg;
        ins_en      = 1'b0;
        ins_byte    = s_tdata;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        ins_en     = 1'b1;
                        total_next = total_inc;
                        if (&total_reg) begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        // length is latched now; the counter is free for the next message
                        len_next   = {(s_tuser ? total_inc : total_reg), 3'b000};
                        total_next = '0;
                    end
                    if (s_tuser && (pos_reg == BLOCK_LAST)) begin
                        state_next  = ST_COMP;
                        resume_next = s_tlast ? ST_PAD_MARK : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_COMP: begin
                round_next = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                state_next = resume_reg;
            end
            ST_PAD_MARK: begin
                ins_en   = 1'b1;
                ins_byte = PAD_BYTE;
                if (pos_reg == BLOCK_LAST) begin
                    // marker filled the block: length goes in an extra block
                    state_next  = ST_COMP;
                    resume_next = ST_PAD_ZERO;
                end else begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (pos_reg == LEN_POS) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    ins_en   = 1'b1;
                    ins_byte = 8'h00;
                    if (pos_reg == BLOCK_LAST) begin
                        // no room for the length here: fill on in a fresh block
                        state_next  = ST_COMP;
                        resume_next = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN: begin
                ins_en   = 1'b1;
                ins_byte = len_reg[63:56];
                len_next = {len_reg[55:0], 8'h00};
                if (pos_reg == BLOCK_LAST) begin
                    state_next  = ST_COMP;
                    resume_next = ST_DIGEST;
                end
            end
            ST_DIGEST: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == WORD_LAST) begin
                        chain_next = INIT_HASH;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pos_next  = ins_en ? pos_reg + 6'd1 : pos_reg;
    assign part_next = ins_en ? {part_reg[15:0], ins_byte} : part_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            round_reg  <= '0;
            idx_reg    <= '0;
            total_reg  <= '0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            chain_reg  <= INIT_HASH;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            pos_reg    <= pos_next;
            chain_reg  <= chain_next;
        end
    end

    // payload only
    always_ff @(posedge aclk) begin
        part_reg <= part_next;
        len_reg  <= len_next;
    end

    assign m_tdata = {5'b00000, idx_reg, chain_reg[idx_reg]};
    assign m_tlast = (idx_reg == WORD_LAST);
    assign m_tuser = ovf_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // input and output never active together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest is offered");

    // a compression always starts on a block boundary
    a_comp_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMP && state_next == ST_COMP) |=> (pos_reg == 6'd0))
        else $error("compression started mid-block");

    // rounds advance by one every cycle of a compression
    a_round_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && round_reg != ROUND_LAST)
        |=> (state_reg == ST_COMP && round_reg == $past(round_reg) + 6'd1))
        else $error("round counter skipped");

    // the digest always starts at word 0 after the final compression
    a_digest_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD && resume_reg == ST_DIGEST) |=> (m_tvalid && idx_reg == 3'd0))
        else $error("digest did not start at word 0");

    // taking word 7 frees the input side
    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && total_reg == 61'd0 && !m_tuser))
        else $error("not idle after the final digest word");

endmodule

### rtl/core/sha256_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word sliding window: filled word by word, then expanded in place.
// ----------------------------------------------------------------------------
module sha256_sched
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  sched_ctrl_t ctrl,
    input  word_t       push_word,
    output word_t       wt
);

    word_t win_reg [16];
    word_t new_word;

    // W[t+16] from the window holding W[t..t+15]
    assign new_word = msg_sigma1(win_reg[14]) + win_reg[9]
                    + msg_sigma0(win_reg[1]) + win_reg[0];
    assign wt = win_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.push || ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= ctrl.push ? push_word : new_word;
        end
    end

endmodule

### rtl/core/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h and one compression round per step.
// ----------------------------------------------------------------------------
module sha256_round
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  round_ctrl_t ctrl,
    input  word_t       chain [8],
    input  word_t       wt,
    input  word_t       k_word,
    output word_t       vars [8]
);

    word_t v_reg [8];
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + k_word + wt;
    assign t2  = big_sigma0(v_reg[0]) + maj;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            v_reg <= chain;
        end else if (ctrl.step) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign vars = v_reg;

endmodule

### tb/sha256_message_hash_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds byte messages through the input stream and keeps its own bit-exact
// SHA-256 (padding, length field and chaining) to predict the eight digest
// words of every message. Each digest word is checked field by field.
// ----------------------------------------------------------------------------
module sha256_message_hash_top_tb;

    // run-away guard on the cycle count
    localparam int CYCLE_LIMIT = 400000;
    // after the last digest word, watch this long for stray output items
    localparam int DRAIN_CYCLES = 200;
    // fewer pending items than this and both sides stop idling
    localparam int CALM_ITEMS = 40;
    localparam int RANDOM_ITEMS = 150;
    localparam int MIN_MESSAGES = 6;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int LEN_SLOT = 56;

    localparam logic [31:0] SHA_ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [7:0] data;
        logic       present;    // item carries a message byte
        logic       eom;        // final item of the message
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_word;
        logic        ovf;
    } digest_item_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sha256_message_hash_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Hash predictor state: chaining words, open block, byte count, overflow
    // ------------------------------------------------------------------------
    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    logic [60:0]  msg_bytes;
    logic         len_ovf;

    byte_item_t   pend_items [$];   // items still to be driven
    digest_item_t digest_q [$];     // digest words awaited, oldest first
    byte_item_t   in_flight;        // item currently on the input bus
    int           mismatches = 0;
    int           src_hold = 0;
    int           sink_hold = 0;
    int           cycle_count = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_block into hash_state
    function automatic void compress_block();
        logic [31:0] sched [64];
        logic [31:0] wv [8];
        logic [31:0] t1, t2, s0, s1;
        int r;
        for (r = 0; r < 64; r++) begin
            if (r < 16) begin
                sched[r] = msg_block[r];
            end else begin
                s0 = ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3);
                s1 = ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10);
                sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
            end
        end
        wv = hash_state;
        for (r = 0; r < 64; r++) begin
            t1 = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + SHA_ROUND_K[r] + sched[r];
            t2 = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++) begin
            hash_state[r] = hash_state[r] + wv[r];
        end
    endfunction

    // big-endian byte placement within the 16-word block
    function automatic void place_byte(input int pos, input logic [7:0] b);
        msg_block[pos / 4][8 * (3 - pos % 4) +: 8] = b;
    endfunction

    // apply one accepted input item; on the end mark, queue the digest words
    function automatic void absorb_item(input byte_item_t it);
        int pos;
        int i;
        logic [63:0] bit_len;
        digest_item_t dw;
        if (it.present) begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, it.data);
            if (msg_bytes == {61{1'b1}}) begin
                len_ovf = 1'b1;
            end
            msg_bytes = msg_bytes + 61'd1;
            if (pos == 63) begin
                compress_block();
            end
        end
        if (it.eom) begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, PAD_MARK);
            for (i = pos + 1; i < 64; i++) begin
                place_byte(i, 8'h00);
            end
            // no room for the length field: close this block, open a blank one
            if (pos >= LEN_SLOT) begin
                compress_block();
                for (i = 0; i < 16; i++) begin
                    msg_block[i] = '0;
                end
            end
            bit_len = {msg_bytes, 3'b000};
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_block();
            for (i = 0; i < 8; i++) begin
                dw = '{hash_state[i], 3'(i), (i == 7), len_ovf};
                digest_q.insert(digest_q.size(), dw);
            end
            hash_state = SHA_IV;
            msg_bytes  = '0;
            len_ovf    = 1'b0;
        end
    endfunction

    function automatic void push_item(input logic [7:0] data, input logic present,
                                      input logic eom);
        byte_item_t it;
        it = '{data, present, eom};
        pend_items.insert(pend_items.size(), it);
    endfunction

    // queue one message of random bytes; returns the number of real items.
    // The end mark either rides on the last byte or follows as its own item.
    // Byte-less, mark-less items are sprinkled in and not counted.
    function automatic int queue_message(input int len, input bit split_end);
        int i;
        int n;
        n = 0;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            push_item(8'($urandom_range(0, 255)), 1'b1, (!split_end && i == len - 1));
            n++;
        end
        if (split_end || len == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            n++;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Input driver: pops pending items, idles in bursts until the run's tail.
    // The predictor sees each item at the edge where it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_item(in_flight);
            end
            if (!s_tvalid || s_tready) begin
                if (src_hold > 0) begin
                    src_hold--;
                    s_tvalid <= 1'b0;
                end else if (pend_items.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0) begin
                    // start an idle burst
                    src_hold = $urandom_range(1, 6) - 1;
                    s_tvalid <= 1'b0;
                end else if (pend_items.size() > 0) begin
                    in_flight = pend_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= in_flight.data;
                    s_tuser  <= in_flight.present;
                    s_tlast  <= in_flight.eom;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure: stall bursts, none near the end
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (pend_items.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Digest checker: each accepted output item against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        digest_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest item %h", m_tdata));
            end else begin
                want = digest_q.pop_front();
                if (m_tdata[31:0] !== want.word) begin
                    report_mismatch($sformatf("word %0d: digest %h, predicted %h",
                                              want.index, m_tdata[31:0], want.word));
                end
                if (m_tdata[34:32] !== want.index) begin
                    report_mismatch($sformatf("word index %0d, predicted %0d",
                                              m_tdata[34:32], want.index));
                end
                if (m_tlast !== want.final_word) begin
                    report_mismatch($sformatf("word %0d: tlast %b, predicted %b",
                                              want.index, m_tlast, want.final_word));
                end
                if (m_tuser !== want.ovf) begin
                    report_mismatch($sformatf("word %0d: overflow flag %b, predicted %b",
                                              want.index, m_tuser, want.ovf));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int stim_items;
        int msgs;
        int len;
        hash_state = SHA_IV;
        foreach (msg_block[i]) msg_block[i] = '0;
        msg_bytes = '0;
        len_ovf   = 1'b0;

        // empty message: end mark alone, byte field at its top value
        push_item(8'hff, 1'b0, 1'b1);
        // one zero byte with the end mark on it
        push_item(8'h00, 1'b1, 1'b1);
        // ignored item inside a message, then 0xff carrying the end mark
        push_item(8'h5a, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b1);
        // "abc" closed by an end mark without a byte
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // two empty messages back to back
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'haa, 1'b0, 1'b1);

        // random messages: mostly short, many ending near the 56-byte padding
        // boundary, a few spanning two or three blocks
        stim_items = 0;
        msgs = 0;
        while (stim_items < RANDOM_ITEMS || msgs < MIN_MESSAGES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(0, 16);
                end
                6, 7, 8: begin
                    len = $urandom_range(52, 68);
                end
                default: begin
                    len = $urandom_range(118, 130);
                end
            endcase
            // trim the closing messages to the item budget
            if (len > RANDOM_ITEMS - stim_items) begin
                len = (stim_items < RANDOM_ITEMS) ? RANDOM_ITEMS - stim_items : 0;
            end
            stim_items += queue_message(len, $urandom_range(0, 2) == 0);
            msgs++;
        end

        // everything driven and every predicted word seen
        @(posedge aresetn);
        while (pend_items.size() != 0 || s_tvalid || digest_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
